### rtl/rrr_pkg.sv
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared types and constants for the round-robin ready ring.
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Largest ring that the four-bit thread identifier can address.
  localparam logic [COUNT_W-1:0] MAX_READY = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADMIT  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_DUP    = 2'd3
  } status_e;

endpackage

### rtl/round_robin_ready_ring_unit.sv
// ----------------------------------------------------------------------------
// round_robin_ready_ring_unit
// Circular ready ring of thread identifiers with admit, remove, next and clear.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   command_i, thread_id_i
// result    out        out_valid_o / out_stall_i chosen_id_o, chosen_valid_o,
//                                                status_o, ready_count_o
//
// One request is taken every cycle unless the result side stalls; each result
// passes from the input register, which reads the link memories, to the result
// register that drives the outputs.
// The ring state is updated as a request leaves the input register, and link
// writes made at that edge are forwarded to the read of the following request.
// A stalled result holds the input register, which then stalls the requester.
// Reset empties the ring at once; the link memories need no clearing.
// ----------------------------------------------------------------------------
module round_robin_ready_ring_unit #(
  parameter int unsigned MAX_THREADS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rrr_pkg::CMD_W-1:0]     command_i,
  input  logic [rrr_pkg::ID_W-1:0]      thread_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrr_pkg::ID_W-1:0]      chosen_id_o,
  output logic                          chosen_valid_o,
  output logic [rrr_pkg::STATUS_W-1:0]  status_o,
  output logic [rrr_pkg::COUNT_W-1:0]   ready_count_o
);

  localparam int unsigned IdxW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned CntW = $clog2(MAX_THREADS + 1);
  localparam int unsigned ExtW = IdxW + rrr_pkg::ID_W + rrr_pkg::COUNT_W;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // Ring state.
  idx_t next_link_q [MAX_THREADS];
  idx_t prev_link_q [MAX_THREADS];
  logic [MAX_THREADS-1:0] present_q, present_d;
  idx_t head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  cnt_t count_q, count_d;

  // Input register.
  logic                 s1_valid_q;
  rrr_pkg::cmd_e        s1_cmd_q;
  logic [rrr_pkg::ID_W-1:0] s1_id_q;
  idx_t                 rd_next_id_q, rd_prev_id_q, rd_next_cur_q;

  // Result register.
  logic                             out_valid_q;
  logic [rrr_pkg::ID_W-1:0]         chosen_id_q, chosen_id_d;
  logic                             chosen_valid_q, chosen_valid_d;
  rrr_pkg::status_e                 status_q, status_d;
  logic [rrr_pkg::COUNT_W-1:0]      ready_count_q;

  logic in_acc, s1_move;
  idx_t in_idx, s1_idx, pred_idx, succ_idx;
  logic s1_in_range, s1_present;
  logic next_we, prev_we;
  idx_t next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [ExtW-1:0] in_ext, s1_ext, cur_ext, cnt_ext;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_ext = ExtW'(thread_id_i);
  assign s1_ext = ExtW'(s1_id_q);
  assign in_idx = in_ext[IdxW-1:0];
  assign s1_idx = s1_ext[IdxW-1:0];
  assign s1_in_range = s1_ext < ExtW'(MAX_THREADS);
  assign s1_present  = s1_in_range && present_q[s1_idx];

  assign pred_idx = (s1_idx == head_q) ? tail_q : rd_prev_id_q;
  assign succ_idx = (s1_idx == tail_q) ? head_q : rd_next_id_q;

  always_comb begin
    present_d      = present_q;
    head_d         = head_q;
    tail_d         = tail_q;
    cur_d          = cur_q;
    count_d        = count_q;
    next_we        = 1'b0;
    prev_we        = 1'b0;
    next_waddr     = tail_q;
    next_wdata     = s1_idx;
    prev_waddr     = s1_idx;
    prev_wdata     = tail_q;
    chosen_valid_d = 1'b0;
    status_d       = rrr_pkg::ST_OK;
    if (s1_move) begin
      unique case (s1_cmd_q)
        rrr_pkg::CMD_ADMIT: begin
          if (!s1_in_range) begin
            status_d = rrr_pkg::ST_ABSENT;
          end else if (s1_present) begin
            status_d = rrr_pkg::ST_DUP;
          end else begin
            present_d[s1_idx] = 1'b1;
            count_d           = count_q + cnt_t'(1);
            tail_d            = s1_idx;
            if (count_q == '0) begin
              head_d = s1_idx;
              cur_d  = s1_idx;
            end else begin
              next_we = 1'b1;
              prev_we = 1'b1;
            end
          end
        end
        rrr_pkg::CMD_REMOVE: begin
          if (count_q == '0) begin
            status_d = rrr_pkg::ST_EMPTY;
          end else if (!s1_present) begin
            status_d = rrr_pkg::ST_ABSENT;
          end else begin
            present_d[s1_idx] = 1'b0;
            count_d           = count_q - cnt_t'(1);
            if (count_q == cnt_t'(1)) begin
              head_d = '0;
              tail_d = '0;
              cur_d  = '0;
            end else begin
              next_we    = (s1_idx != tail_q);
              next_waddr = pred_idx;
              next_wdata = succ_idx;
              prev_we    = (s1_idx != head_q);
              prev_waddr = succ_idx;
              prev_wdata = pred_idx;
              if (s1_idx == head_q) head_d = succ_idx;
              if (s1_idx == tail_q) tail_d = pred_idx;
              if (s1_idx == cur_q)  cur_d  = pred_idx;
            end
          end
        end
        rrr_pkg::CMD_NEXT: begin
          if (count_q == '0) begin
            status_d = rrr_pkg::ST_EMPTY;
          end else begin
            cur_d          = (cur_q == tail_q) ? head_q : rd_next_cur_q;
            chosen_valid_d = 1'b1;
          end
        end
        rrr_pkg::CMD_CLEAR: begin
          present_d = '0;
          head_d    = '0;
          tail_d    = '0;
          cur_d     = '0;
          count_d   = '0;
        end
        default: begin
          status_d = rrr_pkg::ST_OK;
        end
      endcase
    end
  end

  assign cur_ext     = ExtW'(cur_d);
  assign chosen_id_d = chosen_valid_d ? cur_ext[rrr_pkg::ID_W-1:0] : '0;
  assign cnt_ext     = ExtW'(count_d);

  // Link memories: one write and registered write-first reads.
  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_link_q[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_link_q[prev_waddr] <= prev_wdata;
    end
    if (in_acc) begin
      rd_next_id_q  <= (next_we && next_waddr == in_idx) ? next_wdata : next_link_q[in_idx];
      rd_next_cur_q <= (next_we && next_waddr == cur_d) ? next_wdata : next_link_q[cur_d];
      rd_prev_id_q  <= (prev_we && prev_waddr == in_idx) ? prev_wdata : prev_link_q[in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q <= rrr_pkg::cmd_e'(command_i);
      s1_id_q  <= thread_id_i;
    end
    if (s1_move) begin
      chosen_id_q    <= chosen_id_d;
      chosen_valid_q <= chosen_valid_d;
      status_q       <= status_d;
      ready_count_q  <= cnt_ext[rrr_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      present_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cur_q       <= '0;
      count_q     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      present_q <= present_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cur_q     <= cur_d;
      count_q   <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_id_o    = chosen_id_q;
  assign chosen_valid_o = chosen_valid_q;
  assign status_o       = status_q;
  assign ready_count_o  = ready_count_q;

endmodule

### rtl/rrr_checker.sv
// ----------------------------------------------------------------------------
// rrr_checker
// Port-level checks on the round-robin ready ring results.
// ----------------------------------------------------------------------------
module rrr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [rrr_pkg::CMD_W-1:0]     command_i,
  input logic [rrr_pkg::ID_W-1:0]      thread_id_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rrr_pkg::ID_W-1:0]      chosen_id_o,
  input logic                          chosen_valid_o,
  input logic [rrr_pkg::STATUS_W-1:0]  status_o,
  input logic [rrr_pkg::COUNT_W-1:0]   ready_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(chosen_id_o)
      && $stable(status_o) && $stable(ready_count_o))
    else $error("Stalled result changed.");

  a_chosen_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chosen_valid_o |->
      status_o == rrr_pkg::ST_OK && ready_count_o != '0)
    else $error("Selected thread without an occupied ring.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == rrr_pkg::ST_EMPTY |->
      ready_count_o == '0 && !chosen_valid_o)
    else $error("Empty status with a non-zero ready count.");

  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chosen_valid_o |-> chosen_id_o == '0)
    else $error("Thread identifier shown without a selection.");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ready_count_o <= rrr_pkg::MAX_READY)
    else $error("Ready count beyond the identifier range.");

endmodule

bind round_robin_ready_ring_unit rrr_checker u_rrr_checker (.*);

### verif/tb_round_robin_ready_ring_unit.sv
// ----------------------------------------------------------------------------
// tb_round_robin_ready_ring_unit
// Self-checking bench for the round-robin ready ring.
//
// A queue of requests is filled by the stimulus process. It starts with a
// directed sequence that walks the empty, duplicate, absent and wrap-around
// cases, then moves on to random requests that alternately fill and drain
// the ring. A clocked driver offers the requests and predicts every accepted
// one against its own copy of the ring links. A clocked monitor checks each
// result field against the oldest prediction. Both sides idle at random in
// two phases, and in a third one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_round_robin_ready_ring_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_IDS     = 16;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef logic [rrr_pkg::ID_W-1:0] id_t;

  typedef struct packed {
    rrr_pkg::cmd_e cmd;
    id_t           id;
  } ring_req_t;

  typedef struct packed {
    id_t                         chosen_id;
    logic                        chosen_valid;
    rrr_pkg::status_e            status;
    logic [rrr_pkg::COUNT_W-1:0] count;
  } ring_res_t;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          req_valid   = 1'b0;
  logic                          req_stall;
  rrr_pkg::cmd_e                 req_cmd     = rrr_pkg::CMD_NEXT;
  id_t                           req_id      = '0;
  logic                          res_valid;
  logic                          res_stall   = 1'b0;
  id_t                           res_chosen_id;
  logic                          res_chosen_valid;
  logic [rrr_pkg::STATUS_W-1:0]  res_status;
  logic [rrr_pkg::COUNT_W-1:0]   res_count;

  ring_req_t pending_reqs[$];
  ring_res_t expected_results[$];
  int        errors        = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        hold_req      = 0;
  int        hold_ack      = 0;
  int        hold_left     = 0;

  // Predicted ring state.
  id_t                succ_id [NUM_IDS];
  id_t                pred_id [NUM_IDS];
  logic [NUM_IDS-1:0] in_ring  = '0;
  id_t                head_q   = '0;
  id_t                tail_q   = '0;
  id_t                cur_q    = '0;
  int unsigned        live_cnt = 0;

  // Membership as seen by the request generator, used only to bias choices.
  logic [NUM_IDS-1:0] gen_live = '0;

  round_robin_ready_ring_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (req_valid),
    .in_stall_o     (req_stall),
    .command_i      (req_cmd),
    .thread_id_i    (req_id),
    .out_valid_o    (res_valid),
    .out_stall_i    (res_stall),
    .chosen_id_o    (res_chosen_id),
    .chosen_valid_o (res_chosen_valid),
    .status_o       (res_status),
    .ready_count_o  (res_count)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("Mismatch in %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  task automatic ring_predict(input rrr_pkg::cmd_e c, input id_t id);
    ring_res_t r;
    id_t       left_id;
    id_t       right_id;
    r = '{chosen_id: '0, chosen_valid: 1'b0, status: rrr_pkg::ST_OK, count: '0};
    case (c)
      rrr_pkg::CMD_ADMIT: begin
        if (in_ring[id]) begin
          r.status = rrr_pkg::ST_DUP;
        end else begin
          if (live_cnt == 0) begin
            succ_id[id] = id;
            pred_id[id] = id;
            head_q = id;
            tail_q = id;
            cur_q  = id;
          end else begin
            succ_id[tail_q] = id;
            pred_id[id]     = tail_q;
            succ_id[id]     = head_q;
            pred_id[head_q] = id;
            tail_q = id;
          end
          in_ring[id] = 1'b1;
          live_cnt++;
        end
      end
      rrr_pkg::CMD_REMOVE: begin
        if (live_cnt == 0) begin
          r.status = rrr_pkg::ST_EMPTY;
        end else if (!in_ring[id]) begin
          r.status = rrr_pkg::ST_ABSENT;
        end else begin
          in_ring[id] = 1'b0;
          if (live_cnt == 1) begin
            head_q = '0;
            tail_q = '0;
            cur_q  = '0;
            live_cnt = 0;
          end else begin
            left_id  = pred_id[id];
            right_id = succ_id[id];
            succ_id[left_id]  = right_id;
            pred_id[right_id] = left_id;
            if (head_q == id) head_q = right_id;
            if (tail_q == id) tail_q = left_id;
            if (cur_q == id) cur_q = left_id;
            live_cnt--;
          end
        end
      end
      rrr_pkg::CMD_NEXT: begin
        if (live_cnt == 0) begin
          r.status = rrr_pkg::ST_EMPTY;
        end else begin
          cur_q = succ_id[cur_q];
          r.chosen_id    = cur_q;
          r.chosen_valid = 1'b1;
        end
      end
      rrr_pkg::CMD_CLEAR: begin
        in_ring  = '0;
        head_q   = '0;
        tail_q   = '0;
        cur_q    = '0;
        live_cnt = 0;
      end
    endcase
    r.count = live_cnt[rrr_pkg::COUNT_W-1:0];
    expected_results.push_back(r);
  endtask

  task automatic add_req(input rrr_pkg::cmd_e c, input id_t id);
    pending_reqs.push_back('{cmd: c, id: id});
    case (c)
      rrr_pkg::CMD_ADMIT:  gen_live[id] = 1'b1;
      rrr_pkg::CMD_REMOVE: gen_live[id] = 1'b0;
      rrr_pkg::CMD_CLEAR:  gen_live = '0;
      default:             ;
    endcase
  endtask

  function automatic id_t pick_id(input logic want_live);
    id_t cand[$];
    for (int i = 0; i < NUM_IDS; i++) begin
      if (gen_live[i] == want_live) cand.push_back(id_t'(i));
    end
    if (cand.size() == 0 || $urandom_range(99) < 15) return id_t'($urandom_range(NUM_IDS - 1));
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  // The bias swings between filling and draining every forty requests so
  // that the ring regularly reaches both full and empty.
  task automatic gen_random(input int n);
    int roll;
    int admit_pct;
    int remove_pct;
    for (int i = 0; i < n; i++) begin
      admit_pct  = ((i / 40) % 2 == 0) ? 55 : 20;
      remove_pct = ((i / 40) % 2 == 0) ? 20 : 55;
      roll = $urandom_range(99);
      if (roll < admit_pct) begin
        add_req(rrr_pkg::CMD_ADMIT, pick_id(1'b0));
      end else if (roll < admit_pct + remove_pct) begin
        add_req(rrr_pkg::CMD_REMOVE, pick_id(1'b1));
      end else if (roll < 98) begin
        add_req(rrr_pkg::CMD_NEXT, id_t'($urandom_range(NUM_IDS - 1)));
      end else begin
        add_req(rrr_pkg::CMD_CLEAR, id_t'($urandom_range(NUM_IDS - 1)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin : driver
    ring_req_t nxt;
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) ring_predict(req_cmd, req_id);
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_valid <= 1'b1;
          req_cmd   <= nxt.cmd;
          req_id    <= nxt.id;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : receiver
    if (!rst_n) begin
      res_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    ring_res_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding", int'(res_count), 0);
      end else begin
        want = expected_results.pop_front();
        if (res_chosen_id !== want.chosen_id)
          report_mismatch("chosen_id", int'(res_chosen_id), int'(want.chosen_id));
        if (res_chosen_valid !== want.chosen_valid)
          report_mismatch("chosen_valid", int'(res_chosen_valid), int'(want.chosen_valid));
        if (res_status !== want.status)
          report_mismatch("status", int'(res_status), int'(want.status));
        if (res_count !== want.count)
          report_mismatch("ready_count", int'(res_count), int'(want.count));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 7;
    stall_pct     = 87;
    add_req(rrr_pkg::CMD_NEXT, 4'd0);
    add_req(rrr_pkg::CMD_REMOVE, 4'd0);
    add_req(rrr_pkg::CMD_CLEAR, 4'd15);
    add_req(rrr_pkg::CMD_ADMIT, 4'd0);
    add_req(rrr_pkg::CMD_ADMIT, 4'd15);
    add_req(rrr_pkg::CMD_ADMIT, 4'd0);
    add_req(rrr_pkg::CMD_REMOVE, 4'd5);
    add_req(rrr_pkg::CMD_NEXT, 4'd15);
    add_req(rrr_pkg::CMD_NEXT, 4'd0);
    add_req(rrr_pkg::CMD_ADMIT, 4'd7);
    add_req(rrr_pkg::CMD_NEXT, 4'd0);
    add_req(rrr_pkg::CMD_REMOVE, 4'd15);
    add_req(rrr_pkg::CMD_NEXT, 4'd0);
    add_req(rrr_pkg::CMD_REMOVE, 4'd0);
    add_req(rrr_pkg::CMD_ADMIT, 4'd9);
    add_req(rrr_pkg::CMD_REMOVE, 4'd9);
    add_req(rrr_pkg::CMD_REMOVE, 4'd7);
    add_req(rrr_pkg::CMD_NEXT, 4'd0);
    add_req(rrr_pkg::CMD_ADMIT, 4'd10);
    add_req(rrr_pkg::CMD_ADMIT, 4'd5);
    add_req(rrr_pkg::CMD_CLEAR, 4'd0);
    add_req(rrr_pkg::CMD_ADMIT, 4'd5);
    add_req(rrr_pkg::CMD_NEXT, 4'd0);
    gen_random(320);
    wait_drained();

    send_idle_pct = 87;
    stall_pct     = 7;
    gen_random(330);
    wait_drained();

    // With no idling, a long receiver hold-off fills the block and must
    // push the stall back to the request side.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req++;
    gen_random(330);
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
rtl/rrr_pkg.sv
rtl/round_robin_ready_ring_unit.sv
rtl/rrr_checker.sv
verif/tb_round_robin_ready_ring_unit.sv
